@@ rtl/vtd_pkg.sv @@
package vtd_pkg;

  // Converter sample and display widths
  localparam int unsigned SampleWidth  = 10;
  localparam int unsigned VoltWidth    = 6;
  localparam int unsigned SegWidth     = 7;
  localparam int unsigned CountWidth   = 8;

  // Scaling: (avg * 33 + 511) / 1023
  localparam int unsigned ScaleMul     = 33;
  localparam int unsigned ScaleRound   = 511;
  localparam int unsigned ScaleDiv     = 1023;

  localparam logic [CountWidth-1:0] IntervalReset = 8'd20;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [VoltWidth-1:0]   volt_t;
  typedef logic [SegWidth-1:0]    seg_t;
  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [3:0]             digit_t;

  // One display result
  typedef struct packed {
    seg_t segments;
    logic tens_digit_on;
    logic units_digit_on;
  } result_t;

  // Segment patterns, bit0 = a .. bit6 = g
  localparam seg_t Seg0 = 7'h3F;
  localparam seg_t Seg1 = 7'h06;
  localparam seg_t Seg2 = 7'h5B;
  localparam seg_t Seg3 = 7'h4F;
  localparam seg_t Seg4 = 7'h66;
  localparam seg_t Seg5 = 7'h6D;
  localparam seg_t Seg6 = 7'h7D;
  localparam seg_t Seg7 = 7'h07;
  localparam seg_t Seg8 = 7'h7F;
  localparam seg_t Seg9 = 7'h6F;

  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0: s = Seg0;
      4'd1: s = Seg1;
      4'd2: s = Seg2;
      4'd3: s = Seg3;
      4'd4: s = Seg4;
      4'd5: s = Seg5;
      4'd6: s = Seg6;
      4'd7: s = Seg7;
      4'd8: s = Seg8;
      4'd9: s = Seg9;
      default: s = Seg0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/vtd_if.sv @@
// Input channel: one refresh tick with four converter samples
interface vtd_in_if;
  logic               valid;
  logic               ready;
  vtd_pkg::sample_t   sample_first;
  vtd_pkg::sample_t   sample_second;
  vtd_pkg::sample_t   sample_third;
  vtd_pkg::sample_t   sample_fourth;

  modport source (
    output valid, sample_first, sample_second, sample_third, sample_fourth,
    input  ready
  );
  modport sink (
    input  valid, sample_first, sample_second, sample_third, sample_fourth,
    output ready
  );
endinterface

// Result channel: segment pattern and digit enables
interface vtd_out_if;
  logic            valid;
  logic            ready;
  vtd_pkg::seg_t   segments;
  logic            tens_digit_on;
  logic            units_digit_on;

  modport source (
    output valid, segments, tens_digit_on, units_digit_on,
    input  ready
  );
  modport sink (
    input  valid, segments, tens_digit_on, units_digit_on,
    output ready
  );
endinterface

@@ rtl/vtd_scale.sv @@
// Average of four samples scaled to tenths of a volt, 0..33
module vtd_scale (
  input  vtd_pkg::sample_t s0,
  input  vtd_pkg::sample_t s1,
  input  vtd_pkg::sample_t s2,
  input  vtd_pkg::sample_t s3,
  output vtd_pkg::volt_t   volt
);

  logic [11:0] sum;
  logic [9:0]  avg;
  logic [15:0] prod;
  logic [15:0] quot_sum;

  // Floor average
  assign sum = {2'b00, s0} + {2'b00, s1} + {2'b00, s2} + {2'b00, s3};
  assign avg = sum[11:2];

  // avg * 33 + 511 as shift and add
  assign prod = {1'b0, avg, 5'b00000} + {6'b000000, avg}
              + 16'(vtd_pkg::ScaleRound);

  // Divide by 1023: (x + (x >> 10) + 1) >> 10, exact for x < 1023 * 1024
  assign quot_sum = prod + {10'd0, prod[15:10]} + 16'd1;
  assign volt     = quot_sum[15:10];

endmodule

@@ rtl/vtd_seg_enc.sv @@
// Splits the voltage into digits and picks the pattern of the active digit
module vtd_seg_enc (
  input  vtd_pkg::volt_t   volt,
  input  logic             show_tens,
  output vtd_pkg::result_t res
);

  vtd_pkg::digit_t tens;
  vtd_pkg::digit_t units;

  // Value never exceeds 33, so tens is 0..3
  always_comb begin
    if (volt >= 6'd30) begin
      tens  = 4'd3;
      units = 4'(volt - 6'd30);
    end else if (volt >= 6'd20) begin
      tens  = 4'd2;
      units = 4'(volt - 6'd20);
    end else if (volt >= 6'd10) begin
      tens  = 4'd1;
      units = 4'(volt - 6'd10);
    end else begin
      tens  = 4'd0;
      units = volt[3:0];
    end
  end

  always_comb begin
    res.segments       = vtd_pkg::seg_of(show_tens ? tens : units);
    res.tens_digit_on  = show_tens;
    res.units_digit_on = ~show_tens;
  end

endmodule

@@ rtl/voltmeter_two_digit_display.sv @@
// A result passes through the input register and the result register, and is
// valid on the output once the result register holds it.
// Throughput: one item per cycle while the output is not stalled; a stalled
// output holds its result while the input register still takes one more item.
// Reset (synchronous, rst_n low): interval 20, tick count 0, stored
// voltage 0, tens digit first, both channels empty.
module voltmeter_two_digit_display (
  input  logic             clk,
  input  logic             rst_n,
  vtd_in_if.sink           in_ch,
  vtd_out_if.source        out_ch,
  input  logic             cfg_we,
  input  vtd_pkg::count_t  cfg_wdata
);

  vtd_pkg::count_t  interval_r;
  vtd_pkg::count_t  tick_count_r;
  logic             show_tens_r;

  logic             s1_valid_r;
  logic             s1_take_r;
  logic             s1_tens_r;
  vtd_pkg::sample_t s1_smp0_r, s1_smp1_r, s1_smp2_r, s1_smp3_r;

  vtd_pkg::volt_t   stored_volt_r;
  vtd_pkg::volt_t   stored_volt_nxt;
  vtd_pkg::volt_t   scaled;
  vtd_pkg::result_t res;
  vtd_pkg::result_t out_r;
  logic             out_valid_r;

  logic             in_xfer;
  logic             adv2;
  logic [8:0]       count_inc;
  vtd_pkg::count_t  tick_count_nxt;

  // Handshake
  assign adv2        = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = ~s1_valid_r | adv2;
  assign in_xfer     = in_ch.valid & in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= vtd_pkg::IntervalReset;
    end else if (cfg_we) begin
      interval_r <= cfg_wdata;
    end
  end

  // Tick counter wraps at the interval; zero interval acts as one
  assign count_inc      = {1'b0, tick_count_r} + 9'd1;
  assign tick_count_nxt = (count_inc >= {1'b0, interval_r}) ? '0 : count_inc[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      show_tens_r  <= 1'b1;
    end else if (in_xfer) begin
      tick_count_r <= tick_count_nxt;
      show_tens_r  <= ~show_tens_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_take_r <= (tick_count_r == '0);
      s1_tens_r <= show_tens_r;
      s1_smp0_r <= in_ch.sample_first;
      s1_smp1_r <= in_ch.sample_second;
      s1_smp2_r <= in_ch.sample_third;
      s1_smp3_r <= in_ch.sample_fourth;
    end
  end

  // Scale and encode
  vtd_scale u_scale (
    .s0   (s1_smp0_r),
    .s1   (s1_smp1_r),
    .s2   (s1_smp2_r),
    .s3   (s1_smp3_r),
    .volt (scaled)
  );

  assign stored_volt_nxt = s1_take_r ? scaled : stored_volt_r;

  vtd_seg_enc u_seg_enc (
    .volt      (stored_volt_nxt),
    .show_tens (s1_tens_r),
    .res       (res)
  );

  // Stored reading and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_volt_r <= '0;
      out_valid_r   <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        stored_volt_r <= stored_volt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.segments       = out_r.segments;
  assign out_ch.tens_digit_on  = out_r.tens_digit_on;
  assign out_ch.units_digit_on = out_r.units_digit_on;

endmodule
